/* hdl/gregorian_date_difference_macros.svh */
// assertion macros used by the checker of the date difference block
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdd assertion failed");

// antecedent implies consequent after the delay given by dly
`define GDD_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("gdd assertion failed");

`endif

/* hdl/gdd_pkg.sv */
// types, constants and table functions of the date difference block
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int DNUM_W  = DIFF_W - 1;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MON_JAN   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MON_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MON_DEC   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_MIN   = DAY_W'(1);

  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;

  // x / 100 as (x * 5243) >> 19, exact for every 14-bit x
  localparam int DIV100_MUL    = 5243;
  localparam int DIV100_MUL_W  = 13;
  localparam int DIV100_SHIFT  = 19;
  localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;

  typedef struct packed {
    logic              ok;
    logic [DNUM_W-1:0] day_num;
  } gdd_date_info_t;

  function automatic logic [YEAR_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [DIV100_PROD_W-1:0] prod;
    prod = DIV100_PROD_W'(x) * DIV100_PROD_W'(DIV100_MUL);
    return YEAR_W'(prod >> DIV100_SHIFT);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // days before the month in a year counted from march
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

/* hdl/gdd_date_conv.sv */
// date check and day number conversion for one date
module gdd_date_conv (
  input  logic [gdd_pkg::YEAR_W-1:0]  year,
  input  logic [gdd_pkg::MONTH_W-1:0] month,
  input  logic [gdd_pkg::DAY_W-1:0]   day,
  output gdd_pkg::gdd_date_info_t     info
);
  import gdd_pkg::*;

  logic [YEAR_W-1:0] q_y;
  logic [YEAR_W-1:0] r_y;
  logic [YEAR_W-1:0] ya;
  logic [YEAR_W-1:0] q_ya;
  logic              leap;
  logic [DAY_W-1:0]  len;

  always_comb begin
    q_y  = div100(year);
    r_y  = year - YEAR_W'(q_y * YEAR_W'(CENTURY));
    leap = ((year[1:0] == 2'b00) && (r_y != '0)) || ((r_y == '0) && (q_y[1:0] == 2'b00));
    len  = month_len(month, leap);

    // january and february belong to the previous march-based year
    ya   = (month <= MON_FEB) ? year - YEAR_W'(1) : year;
    q_ya = div100(ya);

    info.ok = (year >= YEAR_MIN) && (year <= YEAR_MAX) &&
              (month >= MON_JAN) && (month <= MON_DEC) &&
              (day >= DAY_MIN) && (day <= len);
    info.day_num = DNUM_W'(ya) * DNUM_W'(DAYS_PER_YEAR)
                 + DNUM_W'(ya >> 2)
                 - DNUM_W'(q_ya)
                 + DNUM_W'(q_ya >> 2)
                 + DNUM_W'(month_offset(month))
                 + DNUM_W'(day);
  end

endmodule

/* hdl/gdd_diff_calc.sv */
// signed day difference from two converted dates
module gdd_diff_calc (
  input  gdd_pkg::gdd_date_info_t          first_info,
  input  gdd_pkg::gdd_date_info_t          second_info,
  input  logic                             include_end_day,
  output logic signed [gdd_pkg::DIFF_W-1:0] day_difference,
  output logic                             date_invalid
);
  import gdd_pkg::*;

  logic              earlier;
  logic [DNUM_W-1:0] mag;

  always_comb begin
    earlier = first_info.day_num < second_info.day_num;
    mag     = earlier ? second_info.day_num - first_info.day_num
                      : first_info.day_num - second_info.day_num;
    mag     = mag + DNUM_W'(include_end_day);
    date_invalid = !(first_info.ok && second_info.ok);
    if (date_invalid) begin
      day_difference = '0;
    end else if (earlier) begin
      day_difference = $signed({1'b0, mag});
    end else begin
      day_difference = -$signed({1'b0, mag});
    end
  end

endmodule

/* hdl/gregorian_date_difference.sv */
// top level of the gregorian date difference block
// a result strobes on out_valid for each start that is taken
// throughput: one date pair per cycle, busy stays low, no stall from either side
// pipeline: input register, day number register, result register
// reset: synchronous active-low rst_n clears every valid flag, payload is not reset
module gregorian_date_difference (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gdd_pkg::YEAR_W-1:0]        in_first_year,
  input  logic [gdd_pkg::MONTH_W-1:0]       in_first_month,
  input  logic [gdd_pkg::DAY_W-1:0]         in_first_day,
  input  logic [gdd_pkg::YEAR_W-1:0]        in_second_year,
  input  logic [gdd_pkg::MONTH_W-1:0]       in_second_month,
  input  logic [gdd_pkg::DAY_W-1:0]         in_second_day,
  input  logic                              in_include_end_day,
  output logic                              out_valid,
  output logic signed [gdd_pkg::DIFF_W-1:0] out_day_difference,
  output logic                              out_date_invalid
);
  import gdd_pkg::*;

  // stage 0: captured input beat
  logic               s0_valid_r;
  logic [YEAR_W-1:0]  s0_first_year_r;
  logic [MONTH_W-1:0] s0_first_month_r;
  logic [DAY_W-1:0]   s0_first_day_r;
  logic [YEAR_W-1:0]  s0_second_year_r;
  logic [MONTH_W-1:0] s0_second_month_r;
  logic [DAY_W-1:0]   s0_second_day_r;
  logic               s0_inc_r;

  // stage 1: both dates as day numbers plus validity
  logic               s1_valid_r;
  gdd_date_info_t     s1_first_r;
  gdd_date_info_t     s1_second_r;
  logic               s1_inc_r;
  gdd_date_info_t     s1_first_nxt;
  gdd_date_info_t     s1_second_nxt;

  // stage 2: result register feeding the ports
  logic                     out_valid_r;
  logic signed [DIFF_W-1:0] out_diff_r;
  logic                     out_inv_r;
  logic signed [DIFF_W-1:0] out_diff_nxt;
  logic                     out_inv_nxt;

  // every stage advances each cycle, so a new beat is always welcome
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  // payload captured on every cycle, qualified only by the valid flag
  always_ff @(posedge clk) begin
    s0_first_year_r   <= in_first_year;
    s0_first_month_r  <= in_first_month;
    s0_first_day_r    <= in_first_day;
    s0_second_year_r  <= in_second_year;
    s0_second_month_r <= in_second_month;
    s0_second_day_r   <= in_second_day;
    s0_inc_r          <= in_include_end_day;
  end

  // two converters side by side, one per date
  gdd_date_conv u_first_conv (
    .year  (s0_first_year_r),
    .month (s0_first_month_r),
    .day   (s0_first_day_r),
    .info  (s1_first_nxt)
  );

  gdd_date_conv u_second_conv (
    .year  (s0_second_year_r),
    .month (s0_second_month_r),
    .day   (s0_second_day_r),
    .info  (s1_second_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r  <= s1_first_nxt;
    s1_second_r <= s1_second_nxt;
    s1_inc_r    <= s0_inc_r;
  end

  // subtract, take the sign from the order, add the end day if asked, give zero for an invalid date
  gdd_diff_calc u_diff_calc (
    .first_info      (s1_first_r),
    .second_info     (s1_second_r),
    .include_end_day (s1_inc_r),
    .day_difference  (out_diff_nxt),
    .date_invalid    (out_inv_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_diff_r <= out_diff_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  // result beat is shown for exactly one cycle
  assign out_valid          = out_valid_r;
  assign out_day_difference = out_diff_r;
  assign out_date_invalid   = out_inv_r;

endmodule

/* hdl/gdd_checker.sv */
// port-level checker for the date difference block and its bind
`include "gregorian_date_difference_macros.svh"

module gdd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic signed [gdd_pkg::DIFF_W-1:0] out_day_difference,
  input logic                              out_date_invalid
);
  import gdd_pkg::*;

  localparam int DIFF_LIMIT = 3652060;

  logic diff_zero;
  logic diff_in_range;

  assign diff_zero     = (out_day_difference == '0);
  assign diff_in_range = (out_day_difference <= DIFF_LIMIT) &&
                         (out_day_difference >= -DIFF_LIMIT);

  `GDD_ASSERT_DELAY(a_beat_latency, clk, rst_n, start && !busy, 3, out_valid)
  `GDD_ASSERT_IMPL(a_no_orphan_beat, clk, rst_n, out_valid, $past(start && !busy, 3))
  `GDD_ASSERT_IMPL(a_invalid_gives_zero, clk, rst_n, out_valid && out_date_invalid, diff_zero)
  `GDD_ASSERT_IMPL(a_diff_in_range, clk, rst_n, out_valid, diff_in_range)

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_day_difference (out_day_difference),
  .out_date_invalid   (out_date_invalid)
);
